// File: rtl/wsfp_pkg.sv
`timescale 1ns / 1ps

package wsfp_pkg;

    // Parser phase within a frame
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4,
        PH_HALT = 3'd5
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_RSV       = 2'd0;
    localparam logic [1:0] ERR_UNMASKED  = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd2;
    localparam logic [1:0] ERR_BAD_CTRL  = 2'd3;

    // Header constants
    localparam logic [7:0] HDR_RSV_MASK  = 8'h70;
    localparam logic [6:0] LEN7_EXT16    = 7'd126;
    localparam logic [6:0] LEN7_EXT64    = 7'd127;
    localparam logic [31:0] CTRL_MAX_LEN = 32'd125;
    localparam logic [2:0] EXT16_LEFT    = 3'd1;
    localparam logic [2:0] EXT64_LEFT    = 3'd7;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;

    localparam int OUT_TDATA_W = 48;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  opcode;
        logic        fin;
        logic [7:0]  payload_byte;
        logic [31:0] frame_length;
        logic        last;
        logic [1:0]  error_code;
    } t_result;

endpackage

// File: rtl/websocket_frame_parser_core.sv
`timescale 1ns / 1ps

// A result is registered and appears on the master side in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the output slot is free or drained; the single output
// register with pass-through ready keeps input flowing while a result is taken in the same cycle.
// Reset (i_rst_n, synchronous, active low): parser to frame start, output empty,
// max_payload to 1048576.
module websocket_frame_parser_core
    import wsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: max_payload write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] new_stream
    // Results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [3:0] opcode, [4] fin, [12:5] payload_byte, [44:13] frame_length,
    // [46:45] error_code, [47] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_phase      r_phase, n_phase;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic [31:0] r_len, n_len;          // low 32 bits of the frame length
    logic        r_len_hi, n_len_hi;    // some bit above 31 is set
    logic [2:0]  r_ext_left, n_ext_left;
    logic [31:0] r_mask_key, n_mask_key;
    logic [1:0]  r_mask_seen, n_mask_seen;
    logic [1:0]  r_pidx, n_pidx;        // payload index mod 4 selects key byte
    logic [31:0] r_remain, n_remain;    // payload bytes still to come
    logic [31:0] r_max_payload;

    logic        r_out_valid;
    t_result     r_out;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic w_in_accept;
    logic w_res_valid;
    t_result w_res;

    assign o_cfg_ready   = 1'b1;
    // Take a new byte whenever the output slot is free or being drained now
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Per-byte decode
    // ------------------------------------------------------------------
    t_phase      w_phase;
    logic [7:0]  w_b;
    logic [6:0]  w_len7;
    logic [31:0] w_cand_lo;
    logic        w_cand_hi;
    logic        w_too_long;
    logic        w_bad_ctl;
    logic [7:0]  w_key;

    assign w_b     = s_axis_tdata;
    // new_stream restarts the parser at this very byte
    assign w_phase = s_axis_tuser ? PH_HDR0 : r_phase;
    assign w_len7  = w_b[6:0];

    // Length candidate: from the short field, or the extension bytes shifted in so far
    always_comb begin
        if (w_phase == PH_EXT) begin
            w_cand_lo = {r_len[23:0], w_b};
            w_cand_hi = r_len_hi || (r_len[31:24] != 8'd0);
        end else begin
            w_cand_lo = {25'd0, w_len7};
            w_cand_hi = 1'b0;
        end
    end

    assign w_too_long = w_cand_hi || (w_cand_lo > r_max_payload);
    // Control frames (opcode 8 and up) must be short and unfragmented
    assign w_bad_ctl  = r_opcode[3] && (w_cand_hi || (w_cand_lo > CTRL_MAX_LEN) || !r_fin);

    always_comb begin
        unique case (r_pidx)
            2'd0:    w_key = r_mask_key[31:24];
            2'd1:    w_key = r_mask_key[23:16];
            2'd2:    w_key = r_mask_key[15:8];
            default: w_key = r_mask_key[7:0];
        endcase
    end

    // ------------------------------------------------------------------
    // Next phase
    // ------------------------------------------------------------------
    always_comb begin
        n_phase = w_phase;
        unique case (w_phase)
            PH_HDR0: begin
                n_phase = ((w_b & HDR_RSV_MASK) != 8'd0) ? PH_HALT : PH_HDR1;
            end
            PH_HDR1: begin
                if (!w_b[7]) begin
                    n_phase = PH_HALT;
                end else if (w_len7 == LEN7_EXT16 || w_len7 == LEN7_EXT64) begin
                    n_phase = PH_EXT;
                end else if (w_too_long || w_bad_ctl) begin
                    n_phase = PH_HALT;
                end else begin
                    n_phase = PH_MASK;
                end
            end
            PH_EXT: begin
                if (r_ext_left == 3'd0) begin
                    n_phase = (w_too_long || w_bad_ctl) ? PH_HALT : PH_MASK;
                end
            end
            PH_MASK: begin
                if (r_mask_seen == 2'd3) begin
                    n_phase = (r_len == 32'd0) ? PH_HDR0 : PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_remain == 32'd1) begin
                    n_phase = PH_HDR0;
                end
            end
            PH_HALT: begin
                n_phase = PH_HALT;
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath updates and result
    // ------------------------------------------------------------------
    always_comb begin
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_len       = r_len;
        n_len_hi    = r_len_hi;
        n_ext_left  = r_ext_left;
        n_mask_key  = r_mask_key;
        n_mask_seen = r_mask_seen;
        n_pidx      = r_pidx;
        n_remain    = r_remain;
        w_res_valid = 1'b0;
        w_res       = '0;

        unique case (w_phase)
            PH_HDR0: begin
                n_fin    = w_b[7];
                n_opcode = w_b[3:0];
                n_len    = '0;
                n_len_hi = 1'b0;
                if ((w_b & HDR_RSV_MASK) != 8'd0) begin
                    w_res_valid      = 1'b1;
                    w_res.kind       = KIND_ERROR;
                    w_res.error_code = ERR_RSV;
                end
            end
            PH_HDR1: begin
                n_len    = '0;
                n_len_hi = 1'b0;
                if (!w_b[7]) begin
                    w_res_valid      = 1'b1;
                    w_res.kind       = KIND_ERROR;
                    w_res.error_code = ERR_UNMASKED;
                end else if (w_len7 == LEN7_EXT16) begin
                    n_ext_left = EXT16_LEFT;
                end else if (w_len7 == LEN7_EXT64) begin
                    n_ext_left = EXT64_LEFT;
                end else begin
                    n_len = w_cand_lo;
                    if (w_too_long || w_bad_ctl) begin
                        w_res_valid      = 1'b1;
                        w_res.kind       = KIND_ERROR;
                        w_res.error_code = w_too_long ? ERR_TOO_LONG : ERR_BAD_CTRL;
                    end else begin
                        n_mask_seen = 2'd0;
                        n_mask_key  = '0;
                    end
                end
            end
            PH_EXT: begin
                n_len    = w_cand_lo;
                n_len_hi = w_cand_hi;
                if (r_ext_left == 3'd0) begin
                    if (w_too_long || w_bad_ctl) begin
                        w_res_valid      = 1'b1;
                        w_res.kind       = KIND_ERROR;
                        w_res.error_code = w_too_long ? ERR_TOO_LONG : ERR_BAD_CTRL;
                    end else begin
                        n_mask_seen = 2'd0;
                        n_mask_key  = '0;
                    end
                end else begin
                    n_ext_left = r_ext_left - 3'd1;
                end
            end
            PH_MASK: begin
                n_mask_key = {r_mask_key[23:0], w_b};
                if (r_mask_seen != 2'd3) begin
                    n_mask_seen = r_mask_seen + 2'd1;
                end else begin
                    n_pidx   = 2'd0;
                    n_remain = r_len;
                    if (r_len == 32'd0) begin
                        w_res_valid = 1'b1;
                        w_res.kind  = KIND_EMPTY;
                    end
                end
            end
            PH_DATA: begin
                w_res_valid        = 1'b1;
                w_res.kind         = KIND_PAYLOAD;
                w_res.payload_byte = w_b ^ w_key;
                w_res.frame_length = r_len;
                w_res.last         = (r_remain == 32'd1);
                n_pidx             = r_pidx + 2'd1;
                n_remain           = r_remain - 32'd1;
            end
            PH_HALT: begin
                // drop the byte, no result until new_stream
            end
            default: begin
            end
        endcase

        // Header fields ride along on every result; errors and notices end a frame
        w_res.opcode = n_opcode;
        w_res.fin    = n_fin;
        if (w_res.kind != KIND_PAYLOAD) begin
            w_res.last = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_fin         <= 1'b0;
            r_opcode      <= '0;
            r_len         <= '0;
            r_len_hi      <= 1'b0;
            r_ext_left    <= '0;
            r_mask_key    <= '0;
            r_mask_seen   <= '0;
            r_pidx        <= '0;
            r_remain      <= '0;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_payload <= i_cfg_data;
            end
            if (w_in_accept) begin
                r_phase     <= n_phase;
                r_fin       <= n_fin;
                r_opcode    <= n_opcode;
                r_len       <= n_len;
                r_len_hi    <= n_len_hi;
                r_ext_left  <= n_ext_left;
                r_mask_key  <= n_mask_key;
                r_mask_seen <= n_mask_seen;
                r_pidx      <= n_pidx;
                r_remain    <= n_remain;
            end
        end
    end

    // Output slot: load a fresh result, or empty once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {1'b0, r_out.error_code, r_out.frame_length,
                            r_out.payload_byte, r_out.fin, r_out.opcode};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_res_valid && w_res.kind == KIND_ERROR) |=> (r_phase == PH_HALT))
        else $error("error result without halting the parser");

    a_data_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_remain != 32'd0))
        else $error("payload phase with no bytes remaining");

    a_nonpayload_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD) |-> m_axis_tlast)
        else $error("notice or error result without last");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALT && w_in_accept && !s_axis_tuser) |=> (r_phase == PH_HALT))
        else $error("parser left halt without new_stream");

endmodule
